// ----- design/inversion_counter_defines.svh -----
// Assertion macros shared by the inversion counter modules.
`ifndef INVERSION_COUNTER_DEFINES_SVH
`define INVERSION_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define IC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("inversion counter: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define IC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("inversion counter: next-cycle check failed");

`endif

// ----- design/ic_pkg.sv -----
`timescale 1ns / 1ps
package ic_pkg;

  localparam int CAPACITY_DEFAULT = 1024;
  localparam int VALUE_W          = 31;
  localparam int COUNT_W          = 19;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic signed [VALUE_W-1:0] value_t;

  // Control that travels with each element along the chain
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
  } ic_ctl_t;

endpackage

// ----- design/ic_cell.sv -----
`timescale 1ns / 1ps
module ic_cell #(
  parameter int POS   = 0,
  parameter int IDX_W = 11,
  parameter int CNT_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  ic_pkg::ic_ctl_t     in_ctl,
  input  logic [IDX_W-1:0]    in_idx,
  input  ic_pkg::value_t      in_value,
  input  logic [CNT_W-1:0]    in_cnt,
  output ic_pkg::ic_ctl_t     out_ctl,
  output logic [IDX_W-1:0]    out_idx,
  output ic_pkg::value_t      out_value,
  output logic [CNT_W-1:0]    out_cnt
);
  import ic_pkg::*;

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  value_t stored;
  logic   live;
  logic   hit;

  // Compare against the stored element only when it belongs to an earlier position
  assign live = in_ctl.valid && !in_ctl.ovf;
  assign hit  = live && (in_idx > MY_POS) && (stored > in_value);

  // Capture the element whose position is this cell
  always_ff @(posedge clk) begin
    if (adv && live && (in_idx == MY_POS)) begin
      stored <= in_value;
    end
  end

  // Advance control down the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= in_ctl;
    end
  end

  // Advance payload and partial count
  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx   <= in_idx;
      out_value <= in_value;
      out_cnt   <= hit ? in_cnt + CNT_W'(1) : in_cnt;
    end
  end

endmodule

// ----- design/ic_tail.sv -----
`timescale 1ns / 1ps
`include "inversion_counter_defines.svh"
module ic_tail #(
  parameter int CNT_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  ic_pkg::ic_ctl_t  in_ctl,
  input  logic [CNT_W-1:0] in_cnt,
  output logic             adv,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [18:0] inversions, [23:19] zero
  output logic [0:0]       m_tuser    // [0] overflow
);
  import ic_pkg::*;

  localparam int SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

  logic [COUNT_W-1:0] running;
  logic [COUNT_W-1:0] running_next;
  logic               overflowed;
  logic               overflowed_next;
  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] inversions;
  logic               take;

  // Move the chain whenever the output register is free or being drained
  assign adv  = !m_tvalid || m_tready;
  assign take = adv && in_ctl.valid;

  // Saturating accumulate of this element's count; an overflow element sets the flag instead
  always_comb begin
    sum = SUM_W'(running) + SUM_W'(in_cnt);
    if (in_ctl.ovf) begin
      running_next    = running;
      overflowed_next = 1'b1;
    end else begin
      running_next    = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
      overflowed_next = overflowed;
    end
  end

  // Hold the run totals, clear after the closing element
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= '0;
      overflowed <= 1'b0;
    end else if (take) begin
      if (in_ctl.last) begin
        running    <= '0;
        overflowed <= 1'b0;
      end else begin
        running    <= running_next;
        overflowed <= overflowed_next;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= take && in_ctl.last;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take && in_ctl.last) begin
      inversions <= running_next;
      m_tuser[0] <= overflowed_next;
    end
  end

  assign m_tdata = {5'd0, inversions};

  `IC_ASSERT_NEXT(a_clear_after_last, take && in_ctl.last, (running == '0) && !overflowed)
  `IC_ASSERT_NOW(a_stall_holds_chain, m_tvalid && !m_tready, !adv)

endmodule

// ----- design/inversion_counter.sv -----
`timescale 1ns / 1ps
`include "inversion_counter_defines.svh"
// Channel | Dir | Handshake          | Payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata[30:0] value, s_tlast last
// m_*     | out | m_tvalid/m_tready  | m_tdata[18:0] inversions, m_tuser[0] overflow
//
// One element is taken per cycle while no result stalls; each walks a chain of CAPACITY
// cells, one cell a cycle; the tail registers a run's result after its last element.
// Reset clears control only; stored elements are never cleared, the fill index gates them.
// A stalled result freezes the whole chain and drops s_tready until it is taken.
module inversion_counter #(
  parameter int CAPACITY = ic_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] value, [31] zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [18:0] inversions, [23:19] zero
  output logic [0:0]  m_tuser    // [0] overflow
);
  import ic_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int CNT_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] FULL = IDX_W'(CAPACITY);

  logic             adv;
  logic             accept;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] fill_next;

  ic_ctl_t          ctl   [0:CAPACITY];
  logic [IDX_W-1:0] idx   [0:CAPACITY];
  value_t           value [0:CAPACITY];
  logic [CNT_W-1:0] cnt   [0:CAPACITY];

  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  // Next fill index: advance while room remains, restart after the closing element
  always_comb begin
    fill_next = fill;
    if (accept) begin
      if (s_tlast) begin
        fill_next = '0;
      end else if (fill != FULL) begin
        fill_next = fill + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Head of the chain: a bubble when no request is taken
  always_comb begin
    ctl[0].valid = accept;
    ctl[0].last  = s_tlast;
    ctl[0].ovf   = (fill == FULL);
    idx[0]       = fill;
    value[0]     = s_tdata[VALUE_W-1:0];
    cnt[0]       = '0;
  end

  // Row of compare cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    ic_cell #(
      .POS   (k),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_ctl    (ctl[k]),
      .in_idx    (idx[k]),
      .in_value  (value[k]),
      .in_cnt    (cnt[k]),
      .out_ctl   (ctl[k+1]),
      .out_idx   (idx[k+1]),
      .out_value (value[k+1]),
      .out_cnt   (cnt[k+1])
    );
  end

  // Accumulate counts and present the result
  ic_tail #(
    .CNT_W (CNT_W)
  ) u_tail (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (ctl[CAPACITY]),
    .in_cnt   (cnt[CAPACITY]),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `IC_ASSERT_NEXT(a_fill_restart, accept && s_tlast, fill == '0)
  `IC_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FULL)
  `IC_ASSERT_NOW(a_ovf_only_when_full, ctl[0].valid && ctl[0].ovf, fill == FULL)

endmodule

// ----- verif/inversion_counter_tb.sv -----
`timescale 1ns / 1ps
module inversion_counter_tb;
  import ic_pkg::*;

  localparam int DEPTH        = CAPACITY_DEFAULT;
  localparam int LATENCY      = DEPTH + 1;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 2000;
  localparam int unsigned COUNT_TOP = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic [COUNT_W-1:0] inversions;
    logic               overflow;
  } count_result_t;

  // One request of the directed part; the count is typed in only where marked
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               typed;
    logic [COUNT_W-1:0] inversions;
    logic               overflow;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // single elements straight after reset: largest and smallest in range
    '{31'(1000000000),  1'b1, 1'b1, 19'd0, 1'b0},
    '{31'(-1000000000), 1'b1, 1'b1, 19'd0, 1'b0},
    // descending and ascending pair of range extremes
    '{31'(1000000000),  1'b0, 1'b0, 19'd0, 1'b0},
    '{31'(-1000000000), 1'b1, 1'b1, 19'd1, 1'b0},
    '{31'(-1000000000), 1'b0, 1'b0, 19'd0, 1'b0},
    '{31'(1000000000),  1'b1, 1'b1, 19'd0, 1'b0},
    // out of range: most positive before most negative 31-bit pattern
    '{31'h3FFF_FFFF,    1'b0, 1'b0, 19'd0, 1'b0},
    '{31'h4000_0000,    1'b1, 1'b1, 19'd1, 1'b0},
    // all ones is minus one, so it sorts below zero
    '{31'h7FFF_FFFF,    1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd0,            1'b1, 1'b1, 19'd0, 1'b0},
    '{31'd0,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'h7FFF_FFFF,    1'b1, 1'b1, 19'd1, 1'b0},
    // equal elements never count
    '{31'd5,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd5,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd5,            1'b1, 1'b1, 19'd0, 1'b0},
    // strictly descending triple
    '{31'd3,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd2,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd1,            1'b1, 1'b1, 19'd3, 1'b0},
    // mixed run with a repeat, left to the predictor
    '{31'd7,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'(-3),          1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd12,           1'b0, 1'b0, 19'd0, 1'b0},
    '{31'd0,            1'b0, 1'b0, 19'd0, 1'b0},
    '{31'(-3),          1'b1, 1'b0, 19'd0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] value, [31] zero
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [18:0] inversions, [23:19] zero
  logic [0:0]  m_tuser;        // [0] overflow

  // Predictor state: elements of the open sequence and its running tally
  value_t      seq_vals [DEPTH];
  int unsigned seq_fill = 0;
  int unsigned seq_count = 0;
  logic        seq_ovf = 1'b0;

  count_result_t expected_counts [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  logic input_blocked = 1'b0;

  int items_sent = 0;
  int results_checked = 0;
  int ovf_results = 0;
  int unsigned top_count = 0;
  int fail_count = 0;
  int cycle_count = 0;

  inversion_counter #(
    .CAPACITY(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Add the stored elements greater than the new one; close the sequence on last
  function automatic void predict_count(input value_t v, input logic l,
                                        output logic emitted, output count_result_t res);
    int unsigned greater;
    int k;
    greater = 0;
    emitted = 1'b0;
    res = '0;
    if (seq_fill < DEPTH) begin
      for (k = 0; k < seq_fill; k++)
        if (seq_vals[k] > v) greater++;
      seq_vals[seq_fill] = v;
      seq_fill++;
      if (greater > COUNT_TOP - seq_count) seq_count = COUNT_TOP;
      else seq_count += greater;
    end else begin
      seq_ovf = 1'b1;
    end
    if (l) begin
      emitted = 1'b1;
      res.inversions = seq_count[COUNT_W-1:0];
      res.overflow = seq_ovf;
      seq_fill = 0;
      seq_count = 0;
      seq_ovf = 1'b0;
    end
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 8: return value_t'(int'($urandom_range(0, 2000000000)) - 1000000000);
      4, 5: return value_t'(int'($urandom_range(0, 8)) - 4);
      6: return value_t'($urandom);
      7: begin
        case ($urandom_range(0, 5))
          0: return value_t'(1000000000);
          1: return value_t'(-1000000000);
          2: return 31'h3FFF_FFFF;
          3: return 31'h4000_0000;
          4: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_item(input value_t v, input logic l);
    int wait_run;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, v};
    s_tlast <= l;
    wait_run = 0;
    @(posedge clk);
    while (!s_tready) begin
      wait_run++;
      if (wait_run >= 16) input_blocked = 1'b1;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic drive_and_predict(input value_t v, input logic l, input logic typed,
                                   input count_result_t typed_res);
    logic emitted;
    count_result_t res;
    send_item(v, l);
    predict_count(v, l, emitted, res);
    if (emitted) expected_counts.push_back(typed ? typed_res : res);
  endtask

  // Mostly short sequences, now and then a longer one
  task automatic send_sequence();
    int len;
    int i;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    for (i = 0; i < len; i++)
      drive_and_predict(pick_value(), i == len - 1, 1'b0, '0);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int budget);
    int start;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < budget) send_sequence();
  endtask

  // Check each result against the oldest expected count, then drive ready
  always @(posedge clk) begin
    count_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_counts.size() == 0) begin
          $error("unexpected result: inversions %0d overflow %0d",
                 m_tdata[COUNT_W-1:0], m_tuser[0]);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (m_tdata[COUNT_W-1:0] !== want.inversions) begin
            $error("inversions: expected %0d, got %0d", want.inversions,
                   m_tdata[COUNT_W-1:0]);
            fail_count++;
          end
          if (m_tuser[0] !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, m_tuser[0]);
            fail_count++;
          end
          results_checked++;
          if (want.overflow) ovf_results++;
          if (want.inversions > top_count) top_count = want.inversions;
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Give up on a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("inversion_counter_tb: FAIL");
    $finish;
  end

  initial begin
    count_result_t row_res;
    int k;
    int level;
    int mark;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (k = 0; k < DIR_ROWS; k++) begin
      row_res.inversions = DIR_TABLE[k].inversions;
      row_res.overflow = DIR_TABLE[k].overflow;
      drive_and_predict(DIR_TABLE[k].value, DIR_TABLE[k].last, DIR_TABLE[k].typed, row_res);
    end

    // Random sequences under each idling mix
    run_phase(0, 0, 100);
    run_phase(53, 0, 100);
    run_phase(0, 53, 100);
    run_phase(31, 31, 100);

    // Hold the receiver off while requests keep coming, until the input stalls and 20 more are sent (250 at most)
    tx_idle_pct = 90;
    rx_stall_pct = 0;
    input_blocked = 1'b0;
    hold_req <= hold_req + 1;
    mark = -1;
    k = items_sent;
    while ((mark < 0 || items_sent - mark < 20) && items_sent - k < 250) begin
      send_sequence();
      if (input_blocked && mark < 0) mark = items_sent;
    end

    // One overrun sequence: full capacity strictly descending, then two extra
    // elements, the final one carrying last
    tx_idle_pct = 31;
    rx_stall_pct = 31;
    level = 1000000000;
    for (k = 0; k < DEPTH; k++) begin
      drive_and_predict(value_t'(level), 1'b0, 1'b0, '0);
      level -= $urandom_range(1, 900);
    end
    drive_and_predict(pick_value(), 1'b0, 1'b0, '0);
    drive_and_predict(pick_value(), 1'b1, 1'b0, '0);
    s_tvalid <= 1'b0;

    // Drain, then watch for stray results
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("inversion_counter_tb: %0d elements over directed rows, four idling mixes,",
             items_sent);
    $display("  a held-off receiver and an overrun run; %0d counts checked, %0d overflowed, max %0d",
             results_checked, ovf_results, top_count);
    if (fail_count == 0) begin
      $display("inversion_counter_tb: PASS");
    end else begin
      $display("inversion_counter_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ic_pkg.sv
design/ic_cell.sv
design/ic_tail.sv
design/inversion_counter.sv
verif/inversion_counter_tb.sv
